@@ rtl/core/cmfhf_pkg.sv @@
package cmfhf_pkg;

  // default sizes of the block
  localparam int unsigned MarkersDefault    = 16;
  localparam int unsigned ViewWidthDefault  = 1024;
  localparam int unsigned ViewHeightDefault = 1024;

  // field widths
  localparam int unsigned ModeW  = 2;
  localparam int unsigned EntryW = 4;
  localparam int unsigned CoordW = 10;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SqW    = 2 * ChanW;
  localparam int unsigned DistW  = 18;
  localparam int unsigned CountW = 5;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  // item modes
  localparam logic [ModeW-1:0] ModeLoad  = 2'd0;
  localparam logic [ModeW-1:0] ModePixel = 2'd1;
  localparam logic [ModeW-1:0] ModeFrame = 2'd2;

  // register indexes (word address bit 2)
  localparam logic RegMarkerCount = 1'b0;
  localparam logic RegMatchLimit  = 1'b1;

  localparam logic [DistW-1:0] LimitReset = 18'd7;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [EntryW-1:0] entry_index;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    color_t            color;
  } item_t;

  typedef struct packed {
    logic [EntryW-1:0] marker_index;
    logic [CoordW-1:0] hit_x;
    logic [CoordW-1:0] hit_y;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] marker_count;
    logic [DistW-1:0]  match_limit;
  } cfg_t;

  // squared difference of two channel values
  function automatic logic [SqW-1:0] sq_diff(input logic [ChanW-1:0] a,
                                              input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SqW'(d) * SqW'(d);
  endfunction

endpackage

@@ rtl/core/cmfhf_ifs.sv @@
interface cmfhf_item_if;
  logic                           valid;
  logic                           ready;
  logic [cmfhf_pkg::ModeW-1:0]    mode;
  logic [cmfhf_pkg::EntryW-1:0]   entry_index;
  logic [cmfhf_pkg::CoordW-1:0]   pixel_x;
  logic [cmfhf_pkg::CoordW-1:0]   pixel_y;
  logic [cmfhf_pkg::ChanW-1:0]    red;
  logic [cmfhf_pkg::ChanW-1:0]    green;
  logic [cmfhf_pkg::ChanW-1:0]    blue;

  modport source (output valid, mode, entry_index, pixel_x, pixel_y, red, green, blue,
                  input ready);
  modport sink   (input valid, mode, entry_index, pixel_x, pixel_y, red, green, blue,
                  output ready);
endinterface

interface cmfhf_result_if;
  logic                           valid;
  logic                           ready;
  logic [cmfhf_pkg::EntryW-1:0]   marker_index;
  logic [cmfhf_pkg::CoordW-1:0]   hit_x;
  logic [cmfhf_pkg::CoordW-1:0]   hit_y;

  modport source (output valid, marker_index, hit_x, hit_y, input ready);
  modport sink   (input valid, marker_index, hit_x, hit_y, output ready);
endinterface

@@ rtl/core/cmfhf_cfg.sv @@
module cmfhf_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmfhf_pkg::AddrW-1:0]   paddr,
  input  logic [cmfhf_pkg::DataW-1:0]   pwdata,
  output logic [cmfhf_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output cmfhf_pkg::cfg_t               cfg_o
);
  import cmfhf_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        RegMarkerCount: cfg_d.marker_count = pwdata[CountW-1:0];
        RegMatchLimit:  cfg_d.match_limit  = pwdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker_count <= '0;
      cfg_q.match_limit  <= LimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      RegMarkerCount: prdata = DataW'(cfg_q.marker_count);
      RegMatchLimit:  prdata = DataW'(cfg_q.match_limit);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/cmfhf_lane.sv @@
module cmfhf_lane (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  cmfhf_pkg::color_t             pixel_i,
  input  logic [cmfhf_pkg::DistW-1:0]   limit_i,
  output logic                          match_o
);
  import cmfhf_pkg::*;

  color_t           color_q;
  logic [DistW-1:0] sq_dist;

  // marker color, written by a load item
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      color_q <= pixel_i;
    end
  end

  // squared color distance against the limit
  assign sq_dist = DistW'(sq_diff(pixel_i.red, color_q.red))
                 + DistW'(sq_diff(pixel_i.green, color_q.green))
                 + DistW'(sq_diff(pixel_i.blue, color_q.blue));

  assign match_o = sq_dist < limit_i;

endmodule

@@ rtl/core/color_marker_first_hit_finder_top.sv @@
// Color marker first-hit finder.
// Items arrive on item_i (valid/ready). A load item (mode 0) writes a marker
// color and clears its found flag, a frame-start item (mode 2) clears all found
// flags, and a pixel item (mode 1) with pixel_x below VIEW_WIDTH/2 and pixel_y
// below VIEW_HEIGHT is compared with every active, not yet found marker at
// once. The lowest matching marker is marked found and reported on result_o
// as index and pixel position; a pixel with no match gives no transfer, and
// mode 3 is ignored. A result passes through the input register and then the
// result register. Throughput: one item per cycle while result_o is not
// stalled, set by the single compare stage with all marker lanes in parallel.
// marker_count and match_limit sit on an APB-style port (word at 0 and 4) and
// must be written only while the block is idle; the block does not check it.
// Reset clears the found flags, the pipeline valids, marker_count to 0 and
// match_limit to 7. Marker colors hold no value until loaded.
// When result_o stalls, the held item waits in the input register and
// item_i.ready drops once both registers are full; nothing is lost.
module color_marker_first_hit_finder_top #(
  parameter int unsigned MARKERS     = cmfhf_pkg::MarkersDefault,
  parameter int unsigned VIEW_WIDTH  = cmfhf_pkg::ViewWidthDefault,
  parameter int unsigned VIEW_HEIGHT = cmfhf_pkg::ViewHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cmfhf_item_if.sink                    item_i,
  cmfhf_result_if.source                result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmfhf_pkg::AddrW-1:0]   paddr,
  input  logic [cmfhf_pkg::DataW-1:0]   pwdata,
  output logic [cmfhf_pkg::DataW-1:0]   prdata,
  output logic                          pready
);
  import cmfhf_pkg::*;

  localparam int unsigned IdxW = (MARKERS > 1) ? $clog2(MARKERS) : 1;
  localparam logic [12:0] ColLimit = 13'(VIEW_WIDTH / 2);
  localparam logic [12:0] RowLimit = 13'(VIEW_HEIGHT);

  cfg_t             cfg;
  item_t            s1_q;
  logic             s1_valid_q;
  logic             adv;
  logic             in_view;
  logic [MARKERS-1:0] lane_match, lane_load, active, hit, first;
  logic [MARKERS-1:0] found_q, found_d;
  logic [IdxW-1:0]  hit_idx;
  logic             out_valid_q, out_valid_d;
  result_t          res_q;

  cmfhf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake: the input register moves on when the result register is free
  assign adv          = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || !out_valid_q || result_o.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      s1_q.mode        <= item_i.mode;
      s1_q.entry_index <= item_i.entry_index;
      s1_q.pixel_x     <= item_i.pixel_x;
      s1_q.pixel_y     <= item_i.pixel_y;
      s1_q.color.red   <= item_i.red;
      s1_q.color.green <= item_i.green;
      s1_q.color.blue  <= item_i.blue;
    end
  end

  // one compare lane per marker
  for (genvar m = 0; m < MARKERS; m++) begin : g_lane
    assign lane_load[m] = adv && (s1_q.mode == ModeLoad) && (int'(s1_q.entry_index) == m);
    assign active[m]    = m < int'(cfg.marker_count);

    cmfhf_lane u_lane (
      .clk_i   (clk_i),
      .load_i  (lane_load[m]),
      .pixel_i (s1_q.color),
      .limit_i (cfg.match_limit),
      .match_o (lane_match[m])
    );
  end

  assign in_view = ({3'b000, s1_q.pixel_x} < ColLimit) && ({3'b000, s1_q.pixel_y} < RowLimit);
  assign hit     = (s1_q.mode == ModePixel && in_view) ?
                   (lane_match & active & ~found_q) : '0;
  // lowest set bit wins
  assign first   = hit & (~hit + MARKERS'(1));

  always_comb begin
    hit_idx = '0;
    for (int m = 0; m < MARKERS; m++) begin
      if (first[m]) begin
        hit_idx = hit_idx | IdxW'(m);
      end
    end
  end

  // found flags
  always_comb begin
    found_d = found_q;
    if (adv) begin
      case (s1_q.mode)
        ModeLoad:  found_d = found_q & ~lane_load;
        ModeFrame: found_d = '0;
        ModePixel: found_d = found_q | first;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else begin
      found_q <= found_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      out_valid_d = |hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.marker_index <= EntryW'(hit_idx);
      res_q.hit_x        <= s1_q.pixel_x;
      res_q.hit_y        <= s1_q.pixel_y;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.marker_index = res_q.marker_index;
  assign result_o.hit_x        = res_q.hit_x;
  assign result_o.hit_y        = res_q.hit_y;

endmodule
